// ===== rtl/core/gcp_pkg.sv =====
// ----------------------------------------------------------------------------
// gcp_pkg
// Types, constants and constant functions shared by the gamma correction core.
// ----------------------------------------------------------------------------
package gcp_pkg;

    // Width of a log2 value in unsigned Q16 (three integer bits).
    localparam int LOG_W = 19;
    // Width of the exponent value (three integer bits, sixteen fraction bits).
    localparam int EXP_W = 19;
    // Width of the Q30 mantissa of the power value.
    localparam int MANT_W = 31;

    // Configuration register indexes.
    localparam logic [1:0] REG_GAMMA      = 2'd0;
    localparam logic [1:0] REG_PREV_GAMMA = 2'd1;
    localparam logic [1:0] REG_DEPTH      = 2'd2;

    localparam logic [15:0] GAMMA_RESET = 16'd4096;

    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
        logic [7:0] red_prior;
        logic [7:0] green_prior;
        logic [7:0] blue_prior;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
    } pix_out_t;

    // Data that rides alongside the arithmetic pipeline, per channel.
    typedef struct packed {
        logic [2:0][7:0] x;
        logic [2:0][7:0] prior;
    } side_t;

    // Floor integer square root of a 64-bit value.
    function automatic logic [63:0] isqrt64(input logic [63:0] n_in);
        logic [63:0] n;
        logic [63:0] root;
        logic [63:0] bitv;
        int          i;
        n    = n_in;
        root = '0;
        bitv = 64'd1 << 62;
        for (i = 0; i < 32; i++)
        begin
            if (n >= root + bitv)
            begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
            begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // Q30 value of 2^(-2^-k) for k in 1..16.
    function automatic logic [MANT_W-1:0] exp_coef(input int k);
        logic [63:0] c;
        int          j;
        c = isqrt64(64'd1 << 59);
        for (j = 1; j < 16; j++)
        begin
            if (j < k)
            begin
                c = isqrt64(c << 30);
            end
        end
        return c[MANT_W-1:0];
    endfunction

    // log2 of v in unsigned Q16; zero is taken as one.
    function automatic logic [LOG_W-1:0] log2_q16(input logic [7:0] v);
        logic [7:0]  vv;
        logic [2:0]  n;
        logic [33:0] m;
        logic [15:0] frac;
        int          i;
        vv   = (v == 8'd0) ? 8'd1 : v;
        n    = '0;
        frac = '0;
        for (i = 0; i < 8; i++)
        begin
            if (vv[i])
            begin
                n = 3'(i);
            end
        end
        m = 34'(vv) << (15 - n);
        for (i = 0; i < 16; i++)
        begin
            m    = (m * m) >> 15;
            frac = frac << 1;
            if (m >= 34'h10000)
            begin
                m       = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return {n, frac};
    endfunction

endpackage

// ===== rtl/core/gcp_div.sv =====
// ----------------------------------------------------------------------------
// gcp_div
// Pipelined restoring divider: exponent = floor(d * 2^FB / g), one bit a stage.
// ----------------------------------------------------------------------------
module gcp_div #(
    parameter int GAMMA_FRAC_BITS = 12
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [gcp_pkg::LOG_W-1:0]     d,
    input  logic [15:0]                   g,
    output logic [gcp_pkg::EXP_W-1:0]     e,
    output logic                          ovf
);

    localparam int NS = gcp_pkg::EXP_W;
    localparam int NW = gcp_pkg::LOG_W + GAMMA_FRAC_BITS;

    logic [NW-1:0]  num;
    logic [15:0]    hi;

    logic [15:0]    rem_reg [NS];
    logic [NS-1:0]  lo_reg  [NS];
    logic [NS-1:0]  q_reg   [NS];
    logic           ovf_reg [NS];

    assign num = {d, {GAMMA_FRAC_BITS{1'b0}}};
    assign hi  = 16'(num[NW-1:NS]);

    for (genvar j = 0; j < NS; j++)
    begin : g_stage
        logic [15:0]   rem_prev;
        logic [NS-1:0] lo_prev;
        logic [NS-1:0] q_prev;
        logic          ovf_prev;
        logic [16:0]   trial;
        logic          ge;
        logic [15:0]   rem_next;

        if (j == 0)
        begin : g_first
            // The quotient cannot reach 2^19 unless the top part already
            // meets the divisor, so that compare flags overflow.
            assign rem_prev = hi;
            assign lo_prev  = num[NS-1:0];
            assign q_prev   = '0;
            assign ovf_prev = ({1'b0, hi} >= {1'b0, g});
        end
        else
        begin : g_rest
            assign rem_prev = rem_reg[j-1];
            assign lo_prev  = lo_reg[j-1];
            assign q_prev   = q_reg[j-1];
            assign ovf_prev = ovf_reg[j-1];
        end

        assign trial    = {rem_prev, lo_prev[NS-1]};
        assign ge       = (trial >= {1'b0, g});
        assign rem_next = ge ? 16'(trial - {1'b0, g}) : trial[15:0];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j] <= rem_next;
                lo_reg[j]  <= {lo_prev[NS-2:0], 1'b0};
                q_reg[j]   <= {q_prev[NS-2:0], ge};
                ovf_reg[j] <= ovf_prev;
            end
        end
    end

    assign e   = q_reg[NS-1];
    assign ovf = ovf_reg[NS-1];

endmodule

// ===== rtl/core/gcp_exp.sv =====
// ----------------------------------------------------------------------------
// gcp_exp
// Pipelined 2^-e: one coefficient multiply per fraction bit, then the scale.
// ----------------------------------------------------------------------------
module gcp_exp (
    input  logic                       clk,
    input  logic                       en,
    input  logic [gcp_pkg::EXP_W-1:0]  e,
    output logic [7:0]                 y
);

    localparam int MW = gcp_pkg::MANT_W;

    logic [MW-1:0] v_reg [16];
    logic [15:0]   f_reg [16];
    logic [2:0]    q_reg [16];
    logic [7:0]    y_reg;

    logic [38:0]   scaled;

    for (genvar j = 0; j < 16; j++)
    begin : g_stage
        localparam logic [MW-1:0] CK = gcp_pkg::exp_coef(j + 1);
        logic [MW-1:0]   v_prev;
        logic [15:0]     f_prev;
        logic [2:0]      q_prev;
        logic [2*MW-1:0] prod;

        if (j == 0)
        begin : g_first
            assign v_prev = MW'(1) << 30;
            assign f_prev = e[15:0];
            assign q_prev = e[18:16];
        end
        else
        begin : g_rest
            assign v_prev = v_reg[j-1];
            assign f_prev = f_reg[j-1];
            assign q_prev = q_reg[j-1];
        end

        assign prod = v_prev * CK;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[j] <= f_prev[15-j] ? prod[30 +: MW] : v_prev;
                f_reg[j] <= f_prev;
                q_reg[j] <= q_prev;
            end
        end
    end

    assign scaled = 39'(v_reg[15]) * 39'd255;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg <= 8'(scaled >> (30 + q_reg[15]));
        end
    end

    assign y = y_reg;

endmodule

// ===== rtl/core/gamma_correct_pixel.sv =====
// ----------------------------------------------------------------------------
// gamma_correct_pixel
// Per-pixel 8-bit gamma correction of an RGB pixel with frame clamp rules.
// ----------------------------------------------------------------------------
// How to use it:
// Pixels enter on the input channel (in_valid / in_stall / in_data). Each
// carries the three source bytes and the three previously corrected bytes
// at the same place. Corrected pixels leave on the output channel
// (out_valid / out_stall / out_data), one for each input transfer, in order.
// Gamma, previous gamma and the depth flag are written through the cfg port
// while the core is idle.
// From an input transfer to out_valid a pixel passes, in order, the log
// table register, the one-bit-a-stage divider, the power multiply chain and
// the clamp and output register.
// Throughput is one pixel per clock. While the receiver stalls a waiting
// result, the whole pipeline holds and in_stall is raised, so no new pixel is
// taken until that result has left, even when earlier stages are empty.
// Reset clears every valid bit and loads gamma and previous gamma with one
// point zero and sets the depth flag.
// ----------------------------------------------------------------------------
module gamma_correct_pixel #(
    parameter int GAMMA_FRAC_BITS = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  gcp_pkg::pix_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output gcp_pkg::pix_out_t out_data,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    // Stage 0, then divider and exponent stages, before the output register.
    localparam int LAST = gcp_pkg::EXP_W + 17;
    localparam logic [16:0] ONE = 17'd1 << GAMMA_FRAC_BITS;

    logic [15:0] gamma_reg;
    logic [15:0] prev_gamma_reg;
    logic        depth_reg;

    logic                     valid_reg [LAST+1];
    gcp_pkg::side_t           side_reg  [LAST+1];
    logic [2:0][gcp_pkg::LOG_W-1:0] d_reg;

    logic                     out_valid_reg;
    gcp_pkg::pix_out_t        out_reg;

    logic                     en;
    logic [15:0]              g_eff;
    logic                     darken;
    logic                     brighten;
    logic                     unity;
    logic [gcp_pkg::LOG_W-1:0] log_tab [256];
    logic [2:0][7:0]          x_in;
    logic [2:0][7:0]          prior_in;
    logic [2:0][7:0]          y_corr;
    logic [2:0][7:0]          y_next;
    logic [2:0]               ovf;

    // The whole pipeline moves together unless a finished result is held up.
    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;

    assign g_eff    = (gamma_reg == 16'd0) ? 16'd1 : gamma_reg;
    assign unity    = ({1'b0, gamma_reg} == ONE);
    assign darken   = (gamma_reg < prev_gamma_reg) && ({1'b0, gamma_reg} < ONE);
    assign brighten = (gamma_reg > prev_gamma_reg) && ({1'b0, gamma_reg} > ONE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gamma_reg      <= gcp_pkg::GAMMA_RESET;
            prev_gamma_reg <= gcp_pkg::GAMMA_RESET;
            depth_reg      <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                gcp_pkg::REG_GAMMA:      gamma_reg      <= cfg_data;
                gcp_pkg::REG_PREV_GAMMA: prev_gamma_reg <= cfg_data;
                gcp_pkg::REG_DEPTH:      depth_reg      <= cfg_data[0];
                default:                 ;
            endcase
        end
    end

    // Constant log2 table, folded at elaboration.
    for (genvar i = 0; i < 256; i++)
    begin : g_log
        assign log_tab[i] = gcp_pkg::log2_q16(8'(i));
    end

    assign x_in     = {in_data.red_in, in_data.green_in, in_data.blue_in};
    assign prior_in = {in_data.red_prior, in_data.green_prior, in_data.blue_prior};

    // Valid bits travel with the side data through every stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= LAST; s++)
            begin
                valid_reg[s] <= 1'b0;
            end
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int s = 1; s <= LAST; s++)
            begin
                valid_reg[s] <= valid_reg[s-1];
            end
            out_valid_reg <= valid_reg[LAST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0].x     <= x_in;
            side_reg[0].prior <= prior_in;
            for (int c = 0; c < 3; c++)
            begin
                d_reg[c] <= log_tab[8'd255] - log_tab[x_in[c]];
            end
            for (int s = 1; s <= LAST; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
            out_reg <= y_next;
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        logic [gcp_pkg::EXP_W-1:0] e;

        gcp_div #(
            .GAMMA_FRAC_BITS (GAMMA_FRAC_BITS)
        ) u_div (
            .clk (clk),
            .en  (en),
            .d   (d_reg[c]),
            .g   (g_eff),
            .e   (e),
            .ovf (ovf[c])
        );

        gcp_exp u_exp (
            .clk (clk),
            .en  (en),
            .e   (e),
            .y   (y_corr[c])
        );
    end

    // The overflow flag comes out of the divider seventeen stages before the
    // power result, so it is delayed to line up.
    logic [2:0] ovf_dly_reg [17];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ovf_dly_reg[0] <= ovf;
            for (int s = 1; s < 17; s++)
            begin
                ovf_dly_reg[s] <= ovf_dly_reg[s-1];
            end
        end
    end

    // Special cases, clamp rules on the prior byte, then the depth select.
    always_comb
    begin
        logic [7:0] x;
        logic [7:0] pr;
        logic [7:0] y;
        for (int c = 0; c < 3; c++)
        begin
            x  = side_reg[LAST].x[c];
            pr = side_reg[LAST].prior[c];
            if (x == 8'd0)
            begin
                y = 8'd0;
            end
            else if (x == 8'd255)
            begin
                y = 8'd255;
            end
            else if (unity)
            begin
                y = x;
            end
            else if (ovf_dly_reg[16][c])
            begin
                y = 8'd0;
            end
            else
            begin
                y = y_corr[c];
            end
            if (darken && (y > pr))
            begin
                y = 8'd0;
            end
            if (brighten && (y < pr))
            begin
                y = 8'd255;
            end
            y_next[c] = depth_reg ? y : pr;
        end
    end

    assign out_valid          = out_valid_reg;
    assign out_data.red_out   = out_reg.red_out;
    assign out_data.green_out = out_reg.green_out;
    assign out_data.blue_out  = out_reg.blue_out;

    // A result appears only when an item reached the last pipeline stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(valid_reg[LAST]))
        else $error("output valid without an item in the last stage");

    // With no result waiting the core never pushes back on its input.
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled while the output is empty");

    // An accepted pixel enters the first stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> valid_reg[0])
        else $error("accepted pixel lost at the first stage");

endmodule
